@@ sv/sca_pkg.sv @@
// Shared widths, latencies, types and codes for the sphere closest-approach test.
`timescale 1ns / 1ps
package sca_pkg;
  localparam int AXES       = 3;
  localparam int COORD_W    = 32;
  localparam int TIME_W     = 32;
  localparam int RAD_W      = 31;
  localparam int CF_W       = 16;
  localparam int THR_W      = CF_W + RAD_W;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int FRAC_W     = 16;
  localparam int MAG_W      = 48;
  localparam int HALF_W     = MAG_W / 2;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int ROOT_W     = 49;
  localparam int RADICAND_W = 2 * ROOT_W;
  localparam int DIVD_W     = 64;
  localparam int QUO_W      = 32;
  localparam int DIVN_W     = DIVD_W + QUO_W;
  localparam int DIST_LAT   = 5;
  localparam int SQRT_LAT   = ROOT_W;
  localparam int DIV_LAT    = QUO_W;

  localparam logic [CF_W-1:0]   CLOSE_FACTOR_RST = 16'd512;
  localparam logic [TIME_W-1:0] TIMESTEP_RST     = 32'd65536;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [AXES-1:0] vec3_t;

  typedef enum logic [1:0] {
    OC_NONE      = 2'd0,
    OC_COLLISION = 2'd1,
    OC_CLOSE     = 2'd2
  } outcome_t;

  typedef enum logic {
    REG_CLOSE_FACTOR = 1'b0,
    REG_TIMESTEP     = 1'b1
  } reg_index_t;
endpackage

@@ sv/sphere_closest_approach_test.sv @@
// Top level of the moving-sphere closest-approach collision test pipeline.
`timescale 1ns / 1ps
// Screens one candidate body pair per clock unless the output stalls. For
// each pair whose coarse cells overlap it computes the distance at the start
// of the timestep, at the end, and at the interior time of closest approach,
// and reports a collision with an interpolated contact time, a close
// approach, or no event. Throughput is one transaction per cycle while the
// output is not stalled. An accepted input transaction reaches the output
// register through a 32-stage divider for the closest-approach time, the
// 5-stage distance unit and 49-stage square root, and a second 32-stage
// divider for the contact time. The whole pipeline advances together
// whenever the output register is empty or being taken; an input skid
// register takes one more transaction while the output stalls. Registers
// close_factor (index 0) and timestep_length (index 1) are written through
// the cfg port and must only change while no transaction is in flight.
module sphere_closest_approach_test (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [31:0]                       cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              cell_overlap,
  input  logic signed [sca_pkg::COORD_W-1:0] rel_pos_x,
  input  logic signed [sca_pkg::COORD_W-1:0] rel_pos_y,
  input  logic signed [sca_pkg::COORD_W-1:0] rel_pos_z,
  input  logic signed [sca_pkg::COORD_W-1:0] rel_vel_x,
  input  logic signed [sca_pkg::COORD_W-1:0] rel_vel_y,
  input  logic signed [sca_pkg::COORD_W-1:0] rel_vel_z,
  input  logic [sca_pkg::RAD_W-1:0]         radius_sum,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        outcome,
  output logic [sca_pkg::TIME_W-1:0]        proximity_time,
  output logic [sca_pkg::RAD_W-1:0]         contact_distance
);
  localparam int DS_LAT = sca_pkg::DIST_LAT + sca_pkg::SQRT_LAT;
  localparam int RW     = sca_pkg::ROOT_W;

  typedef struct packed {
    logic                          ov;
    logic                          maybe;
    sca_pkg::vec3_t                pos;
    sca_pkg::vec3_t                vel;
    logic [sca_pkg::RAD_W-1:0]     rad;
    logic [sca_pkg::THR_W-1:0]     thr;
  } a_t;

  typedef struct packed {
    logic                          ov;
    logic                          interior;
    logic [sca_pkg::TIME_W-1:0]    mt;
    logic [sca_pkg::RAD_W-1:0]     rad;
    logic [sca_pkg::THR_W-1:0]     thr;
  } b_t;

  typedef struct packed {
    sca_pkg::outcome_t             oc;
    logic                          time_zero;
    logic [sca_pkg::TIME_W-1:0]    tstep;
    logic [sca_pkg::RAD_W-1:0]     dist_val;
  } c_t;

  // configuration registers
  logic [sca_pkg::CF_W-1:0]   close_factor;
  logic [sca_pkg::TIME_W-1:0] timestep_length;

  logic en;

  // stage 0: skid register
  logic                        s0_valid;
  logic                        s0_ov;
  sca_pkg::vec3_t              s0_pos, s0_vel;
  logic [sca_pkg::RAD_W-1:0]   s0_rad;

  // stage 1: products
  logic                        s1_valid, s1_ov;
  sca_pkg::vec3_t              s1_pos, s1_vel;
  logic [sca_pkg::RAD_W-1:0]   s1_rad;
  logic [sca_pkg::THR_W-1:0]   s1_thr;
  logic [sca_pkg::PROD_W-1:0]  s1_vv [sca_pkg::AXES];
  logic [sca_pkg::PROD_W-1:0]  s1_pv [sca_pkg::AXES];
  logic [sca_pkg::AXES-1:0]    s1_mis;
  logic [sca_pkg::COORD_W-1:0] pmag [sca_pkg::AXES];
  logic [sca_pkg::COORD_W-1:0] vmag [sca_pkg::AXES];

  // stage 2: sums
  logic                        s2_valid, s2_ov;
  sca_pkg::vec3_t              s2_pos, s2_vel;
  logic [sca_pkg::RAD_W-1:0]   s2_rad;
  logic [sca_pkg::THR_W-1:0]   s2_thr;
  logic [sca_pkg::PROD_W-1:0]  s2_vv, s2_pos_sum, s2_neg_sum;
  logic [sca_pkg::PROD_W-1:0]  pos_acc, neg_acc;

  // stage 3: numerator of the closest-approach time
  logic                        s3_valid;
  a_t                          s3;
  logic [sca_pkg::PROD_W-1:0]  s3_num, s3_vv;
  logic [sca_pkg::PROD_W-1:0]  num_diff;

  // closest-approach divider and its side line
  logic [sca_pkg::DIV_LAT-1:0] a_valid;
  a_t                          a_pipe [sca_pkg::DIV_LAT];
  logic [sca_pkg::QUO_W-1:0]   mt_quo;

  // stage 4: interior decision, distance launch
  logic                        s4_valid;
  a_t                          s4;
  logic                        s4_interior;
  logic [sca_pkg::TIME_W-1:0]  s4_mt;
  logic [sca_pkg::RADICAND_W-1:0] sq_start, sq_end, sq_min;
  logic [RW-1:0]               ds, de, dm;

  logic [DS_LAT-1:0]           b_valid;
  b_t                          b_pipe [DS_LAT];
  b_t                          bl;

  // stage 5: candidate selection
  logic                        s5_valid, s5_ev;
  logic [RW-1:0]               s5_dmin, s5_ds;
  logic [sca_pkg::TIME_W-1:0]  s5_tstep;
  logic [sca_pkg::RAD_W-1:0]   s5_rad;
  logic [sca_pkg::THR_W-1:0]   s5_thr;
  logic                        reject, cand_int, cand_end;

  // stage 6: classification
  logic                        s6_valid;
  c_t                          s6;
  logic [RW-1:0]               s6_adiff, s6_ddiff;
  sca_pkg::outcome_t           oc_next;
  logic                        coll, near;

  // stage 7: contact time numerator partial products
  logic                        s7_valid;
  c_t                          s7;
  logic [RW-1:0]               s7_ddiff;
  logic [sca_pkg::PROD_W-1:0]  s7_pp_lo;
  logic [sca_pkg::TIME_W+RW-sca_pkg::COORD_W-1:0] s7_pp_hi;

  // stage 8: divider operands
  logic                        s8_valid;
  c_t                          s8;
  logic [sca_pkg::DIVN_W-1:0]  s8_dividend;
  logic [sca_pkg::DIVD_W-1:0]  s8_divisor;

  logic [sca_pkg::DIV_LAT-1:0] c_valid;
  c_t                          c_pipe [sca_pkg::DIV_LAT];
  c_t                          cl;
  logic [sca_pkg::QUO_W-1:0]   ct_quo;

  logic [sca_pkg::TIME_W-1:0]  time_next;
  logic [sca_pkg::RAD_W-1:0]   dist_next;

  // ---------------------------------------------------------------------
  // Configuration: always ready; must be written only while pipeline empty.
  // ---------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      close_factor    <= sca_pkg::CLOSE_FACTOR_RST;
      timestep_length <= sca_pkg::TIMESTEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sca_pkg::reg_index_t'(cfg_index))
        sca_pkg::REG_CLOSE_FACTOR: close_factor    <= cfg_data[sca_pkg::CF_W-1:0];
        sca_pkg::REG_TIMESTEP:     timestep_length <= cfg_data;
        default:                   close_factor    <= close_factor;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Flow control: every stage advances when the output register frees up.
  // An empty skid register still takes a transaction while the pipe is held.
  // ---------------------------------------------------------------------
  assign en       = !out_valid || !out_stall;
  assign in_stall = s0_valid && !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en || !s0_valid) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en || !s0_valid) begin
      s0_ov  <= cell_overlap;
      s0_pos <= {rel_pos_z, rel_pos_y, rel_pos_x};
      s0_vel <= {rel_vel_z, rel_vel_y, rel_vel_x};
      s0_rad <= radius_sum;
    end
  end

  // valid bits for the whole pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      a_valid   <= '0;
      s4_valid  <= 1'b0;
      b_valid   <= '0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      s8_valid  <= 1'b0;
      c_valid   <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= s0_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      a_valid   <= {a_valid[sca_pkg::DIV_LAT-2:0], s3_valid};
      s4_valid  <= a_valid[sca_pkg::DIV_LAT-1];
      b_valid   <= {b_valid[DS_LAT-2:0], s4_valid};
      s5_valid  <= b_valid[DS_LAT-1];
      s6_valid  <= s5_valid;
      s7_valid  <= s6_valid;
      s8_valid  <= s7_valid;
      c_valid   <= {c_valid[sca_pkg::DIV_LAT-2:0], s8_valid};
      out_valid <= c_valid[sca_pkg::DIV_LAT-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stages 1-3: |v|^2, p.v split by sign, and the numerator -(p.v).
  // ---------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < sca_pkg::AXES; k++) begin
      pmag[k] = s0_pos[k][sca_pkg::COORD_W-1] ? (~s0_pos[k] + 32'd1) : s0_pos[k];
      vmag[k] = s0_vel[k][sca_pkg::COORD_W-1] ? (~s0_vel[k] + 32'd1) : s0_vel[k];
    end
    pos_acc = '0;
    neg_acc = '0;
    for (int k = 0; k < sca_pkg::AXES; k++) begin
      if (s1_mis[k]) neg_acc = neg_acc + s1_pv[k];
      else           pos_acc = pos_acc + s1_pv[k];
    end
    num_diff = s2_neg_sum - s2_pos_sum;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ov  <= s0_ov;
      s1_pos <= s0_pos;
      s1_vel <= s0_vel;
      s1_rad <= s0_rad;
      s1_thr <= sca_pkg::THR_W'(close_factor) * sca_pkg::THR_W'(s0_rad);
      for (int k = 0; k < sca_pkg::AXES; k++) begin
        s1_vv[k]  <= sca_pkg::PROD_W'(vmag[k]) * sca_pkg::PROD_W'(vmag[k]);
        s1_pv[k]  <= sca_pkg::PROD_W'(pmag[k]) * sca_pkg::PROD_W'(vmag[k]);
        s1_mis[k] <= s0_pos[k][sca_pkg::COORD_W-1] ^ s0_vel[k][sca_pkg::COORD_W-1];
      end

      s2_ov      <= s1_ov;
      s2_pos     <= s1_pos;
      s2_vel     <= s1_vel;
      s2_rad     <= s1_rad;
      s2_thr     <= s1_thr;
      s2_vv      <= s1_vv[0] + s1_vv[1] + s1_vv[2];
      s2_pos_sum <= pos_acc;
      s2_neg_sum <= neg_acc;

      // an interior minimum needs p.v < 0 and a quotient that fits 32 bits
      s3.ov    <= s2_ov;
      s3.maybe <= (s2_neg_sum > s2_pos_sum)
               && (num_diff[sca_pkg::PROD_W-1:sca_pkg::FRAC_W] < s2_vv);
      s3.pos   <= s2_pos;
      s3.vel   <= s2_vel;
      s3.rad   <= s2_rad;
      s3.thr   <= s2_thr;
      s3_num   <= num_diff;
      s3_vv    <= s2_vv;
    end
  end

  sca_div u_mt_div (
    .clk      (clk),
    .en       (en),
    .dividend ({16'd0, s3_num, 16'd0}),
    .divisor  (s3_vv),
    .quotient (mt_quo)
  );

  // hold the pair alongside the divider
  always_ff @(posedge clk) begin
    if (en) begin
      a_pipe[0] <= s3;
      for (int i = 1; i < sca_pkg::DIV_LAT; i++) a_pipe[i] <= a_pipe[i-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: decide on the interior minimum, launch three distance units.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      s4          <= a_pipe[sca_pkg::DIV_LAT-1];
      s4_interior <= a_pipe[sca_pkg::DIV_LAT-1].maybe && (mt_quo < timestep_length);
      s4_mt       <= mt_quo;
    end
  end

  sca_dist u_dist_start (
    .clk (clk), .en (en), .pos (s4.pos), .vel (s4.vel), .t ('0), .dist_sq (sq_start)
  );
  sca_dist u_dist_end (
    .clk (clk), .en (en), .pos (s4.pos), .vel (s4.vel), .t (timestep_length),
    .dist_sq (sq_end)
  );
  sca_dist u_dist_min (
    .clk (clk), .en (en), .pos (s4.pos), .vel (s4.vel),
    .t (s4_interior ? s4_mt : '0), .dist_sq (sq_min)
  );

  sca_sqrt u_sqrt_start (.clk (clk), .en (en), .radicand (sq_start), .root (ds));
  sca_sqrt u_sqrt_end   (.clk (clk), .en (en), .radicand (sq_end),   .root (de));
  sca_sqrt u_sqrt_min   (.clk (clk), .en (en), .radicand (sq_min),   .root (dm));

  always_ff @(posedge clk) begin
    if (en) begin
      b_pipe[0].ov       <= s4.ov;
      b_pipe[0].interior <= s4_interior;
      b_pipe[0].mt       <= s4_mt;
      b_pipe[0].rad      <= s4.rad;
      b_pipe[0].thr      <= s4.thr;
      for (int i = 1; i < DS_LAT; i++) b_pipe[i] <= b_pipe[i-1];
    end
  end

  assign bl = b_pipe[DS_LAT-1];

  // ---------------------------------------------------------------------
  // Stage 5: pick the candidate (interior minimum, else the end point).
  // ---------------------------------------------------------------------
  always_comb begin
    reject   = !bl.interior && ({de, 8'd0} > (RW + 8)'(bl.thr));
    cand_int = bl.interior && (dm <= de) && (dm < ds);
    cand_end = !cand_int && (de < (bl.interior ? dm : ds)) && (de < ds);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_ev    <= bl.ov && !reject && (cand_int || cand_end);
      s5_dmin  <= cand_int ? dm : de;
      s5_tstep <= cand_int ? bl.mt : timestep_length;
      s5_ds    <= ds;
      s5_rad   <= bl.rad;
      s5_thr   <= bl.thr;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: collision, close approach, or drop to no event.
  // ---------------------------------------------------------------------
  always_comb begin
    coll = s5_dmin <= RW'(s5_rad);
    near = {s5_dmin, 8'd0} < (RW + 8)'(s5_thr);
    if (!s5_ev)    oc_next = sca_pkg::OC_NONE;
    else if (coll) oc_next = sca_pkg::OC_COLLISION;
    else if (near) oc_next = sca_pkg::OC_CLOSE;
    else           oc_next = sca_pkg::OC_NONE;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6.oc        <= oc_next;
      s6.time_zero <= s5_ds <= RW'(s5_rad);
      s6.tstep     <= s5_tstep;
      if (coll)
        s6.dist_val <= s5_rad;
      else if (s5_dmin > RW'({sca_pkg::RAD_W{1'b1}}))
        s6.dist_val <= {sca_pkg::RAD_W{1'b1}};
      else
        s6.dist_val <= s5_dmin[sca_pkg::RAD_W-1:0];
      s6_adiff <= s5_ds - RW'(s5_rad);
      s6_ddiff <= s5_ds - s5_dmin;

      // tstep * (ds - rad) in two partial products
      s7       <= s6;
      s7_ddiff <= s6_ddiff;
      s7_pp_lo <= sca_pkg::PROD_W'(s6.tstep) * sca_pkg::PROD_W'(s6_adiff[31:0]);
      s7_pp_hi <= ($bits(s7_pp_hi))'(s6.tstep) * ($bits(s7_pp_hi))'(s6_adiff[RW-1:32]);

      s8          <= s7;
      s8_dividend <= sca_pkg::DIVN_W'(s7_pp_lo) + (sca_pkg::DIVN_W'(s7_pp_hi) << 32);
      s8_divisor  <= sca_pkg::DIVD_W'(s7_ddiff);
    end
  end

  sca_div u_ct_div (
    .clk      (clk),
    .en       (en),
    .dividend (s8_dividend),
    .divisor  (s8_divisor),
    .quotient (ct_quo)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      c_pipe[0] <= s8;
      for (int i = 1; i < sca_pkg::DIV_LAT; i++) c_pipe[i] <= c_pipe[i-1];
    end
  end

  assign cl = c_pipe[sca_pkg::DIV_LAT-1];

  // ---------------------------------------------------------------------
  // Output register: zero the fields when there is no event.
  // ---------------------------------------------------------------------
  always_comb begin
    case (cl.oc)
      sca_pkg::OC_COLLISION: begin
        time_next = cl.time_zero ? '0 : ct_quo;
        dist_next = cl.dist_val;
      end
      sca_pkg::OC_CLOSE: begin
        time_next = cl.tstep;
        dist_next = cl.dist_val;
      end
      default: begin
        time_next = '0;
        dist_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      outcome          <= cl.oc;
      proximity_time   <= time_next;
      contact_distance <= dist_next;
    end
  end

`ifndef ASSERT_OFF
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == sca_pkg::OC_NONE |-> proximity_time == '0 && contact_distance == '0)
    else $error("no-event transaction carries nonzero fields");

  a_close_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == sca_pkg::OC_CLOSE |-> contact_distance != '0)
    else $error("close approach with zero distance");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s0_valid)
    else $error("pipeline not empty after reset");
`endif
endmodule

@@ sv/sca_dist.sv @@
// Pipelined squared distance of a moving relative position at a given time.
`timescale 1ns / 1ps
module sca_dist (
  input  logic                              clk,
  input  logic                              en,
  input  sca_pkg::vec3_t                    pos,
  input  sca_pkg::vec3_t                    vel,
  input  logic [sca_pkg::TIME_W-1:0]        t,
  output logic [sca_pkg::RADICAND_W-1:0]    dist_sq
);
  logic signed [sca_pkg::PROD_W:0]     prod_full [sca_pkg::AXES];
  logic signed [sca_pkg::PROD_W-1:0]   prod_q [sca_pkg::AXES];
  sca_pkg::vec3_t                      pos_q;
  logic signed [sca_pkg::MAG_W:0]      pt [sca_pkg::AXES];
  logic [sca_pkg::MAG_W-1:0]           mag_q [sca_pkg::AXES];
  logic [2*sca_pkg::HALF_W-1:0]        hh_q [sca_pkg::AXES];
  logic [2*sca_pkg::HALF_W-1:0]        hl_q [sca_pkg::AXES];
  logic [2*sca_pkg::HALF_W-1:0]        ll_q [sca_pkg::AXES];
  logic [sca_pkg::SQ_W-1:0]            sq_q [sca_pkg::AXES];

  always_comb begin
    for (int k = 0; k < sca_pkg::AXES; k++) begin
      prod_full[k] = $signed(vel[k]) * $signed({1'b0, t});
      pt[k] = (sca_pkg::MAG_W + 1)'($signed(pos_q[k]))
            + (sca_pkg::MAG_W + 1)'($signed(prod_q[k][sca_pkg::PROD_W-1:sca_pkg::FRAC_W]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_q <= pos;
      for (int k = 0; k < sca_pkg::AXES; k++) begin
        // v*t, then floor shift to Q24.8 and add the start position
        prod_q[k] <= prod_full[k][sca_pkg::PROD_W-1:0];
        mag_q[k]  <= pt[k][sca_pkg::MAG_W] ? sca_pkg::MAG_W'(-pt[k])
                                           : pt[k][sca_pkg::MAG_W-1:0];
        // square in halves
        hh_q[k] <= mag_q[k][sca_pkg::MAG_W-1:sca_pkg::HALF_W]
                 * mag_q[k][sca_pkg::MAG_W-1:sca_pkg::HALF_W];
        hl_q[k] <= mag_q[k][sca_pkg::MAG_W-1:sca_pkg::HALF_W]
                 * mag_q[k][sca_pkg::HALF_W-1:0];
        ll_q[k] <= mag_q[k][sca_pkg::HALF_W-1:0] * mag_q[k][sca_pkg::HALF_W-1:0];
        sq_q[k] <= (sca_pkg::SQ_W'(hh_q[k]) << sca_pkg::MAG_W)
                 + (sca_pkg::SQ_W'(hl_q[k]) << (sca_pkg::HALF_W + 1))
                 + sca_pkg::SQ_W'(ll_q[k]);
      end
      dist_sq <= sca_pkg::RADICAND_W'(sq_q[0]) + sca_pkg::RADICAND_W'(sq_q[1])
               + sca_pkg::RADICAND_W'(sq_q[2]);
    end
  end
endmodule

@@ sv/sca_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module sca_sqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [sca_pkg::RADICAND_W-1:0] radicand,
  output logic [sca_pkg::ROOT_W-1:0]     root
);
  logic [sca_pkg::RADICAND_W-1:0] rem  [0:sca_pkg::ROOT_W];
  logic [sca_pkg::ROOT_W-1:0]     part [0:sca_pkg::ROOT_W];

  assign rem[0]  = radicand;
  assign part[0] = '0;

  for (genvar s = 1; s <= sca_pkg::ROOT_W; s++) begin : g_bit
    localparam int B = sca_pkg::ROOT_W - s;
    logic [sca_pkg::RADICAND_W-1:0] trial;

    // (r + 2^B)^2 - r^2
    always_comb trial = (sca_pkg::RADICAND_W'(part[s-1]) << (B + 1))
                      | (sca_pkg::RADICAND_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[s-1] >= trial) begin
          rem[s]  <= rem[s-1] - trial;
          part[s] <= part[s-1] | (sca_pkg::ROOT_W'(1) << B);
        end else begin
          rem[s]  <= rem[s-1];
          part[s] <= part[s-1];
        end
      end
    end
  end

  assign root = part[sca_pkg::ROOT_W];
endmodule

@@ sv/sca_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module sca_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [sca_pkg::DIVN_W-1:0] dividend,
  input  logic [sca_pkg::DIVD_W-1:0] divisor,
  output logic [sca_pkg::QUO_W-1:0]  quotient
);
  logic [sca_pkg::DIVD_W-1:0] rem [0:sca_pkg::QUO_W];
  logic [sca_pkg::QUO_W-1:0]  nq  [0:sca_pkg::QUO_W];
  logic [sca_pkg::DIVD_W-1:0] dv  [0:sca_pkg::QUO_W];

  // dividend high half must already be below the divisor
  assign rem[0] = dividend[sca_pkg::DIVN_W-1:sca_pkg::QUO_W];
  assign nq[0]  = dividend[sca_pkg::QUO_W-1:0];
  assign dv[0]  = divisor;

  for (genvar s = 1; s <= sca_pkg::QUO_W; s++) begin : g_bit
    logic [sca_pkg::DIVD_W:0] shifted;
    logic [sca_pkg::DIVD_W:0] diff;

    always_comb begin
      shifted = {rem[s-1], nq[s-1][sca_pkg::QUO_W-1]};
      diff    = shifted - {1'b0, dv[s-1]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[s] <= dv[s-1];
        if (shifted >= {1'b0, dv[s-1]}) begin
          rem[s] <= diff[sca_pkg::DIVD_W-1:0];
          nq[s]  <= {nq[s-1][sca_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem[s] <= shifted[sca_pkg::DIVD_W-1:0];
          nq[s]  <= {nq[s-1][sca_pkg::QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quotient = nq[sca_pkg::QUO_W];
endmodule

@@ bench/tb.sv @@
// Testbench for the sphere closest-approach test: directed pairs, random pairs, backpressure.
`timescale 1ns / 1ps
module tb;
  import sca_pkg::*;

  // One candidate pair as it goes into the block.
  typedef struct {
    logic              overlap;
    coord_t            pos [AXES];
    coord_t            vel [AXES];
    logic [RAD_W-1:0]  rad;
  } pair_t;

  // One screening verdict as it comes out of the block.
  typedef struct {
    outcome_t          oc;
    logic [TIME_W-1:0] t;
    logic [RAD_W-1:0]  d;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  reg_index_t          cfg_index = REG_CLOSE_FACTOR;
  logic [31:0]         cfg_data = '0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                cell_overlap = 1'b0;
  coord_t              rel_pos_x = '0, rel_pos_y = '0, rel_pos_z = '0;
  coord_t              rel_vel_x = '0, rel_vel_y = '0, rel_vel_z = '0;
  logic [RAD_W-1:0]    radius_sum = '0;

  logic                out_valid;
  logic                out_stall = 1'b1;
  logic [1:0]          outcome;
  logic [TIME_W-1:0]   proximity_time;
  logic [RAD_W-1:0]    contact_distance;

  sphere_closest_approach_test dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cell_overlap(cell_overlap),
    .rel_pos_x(rel_pos_x), .rel_pos_y(rel_pos_y), .rel_pos_z(rel_pos_z),
    .rel_vel_x(rel_vel_x), .rel_vel_y(rel_vel_y), .rel_vel_z(rel_vel_z),
    .radius_sum(radius_sum),
    .out_valid(out_valid), .out_stall(out_stall), .outcome(outcome),
    .proximity_time(proximity_time), .contact_distance(contact_distance)
  );

  // Local copy of the two registers, updated on each accepted config write.
  logic [CF_W-1:0]   close_mult = CLOSE_FACTOR_RST;
  logic [TIME_W-1:0] step_len   = TIMESTEP_RST;

  verdict_t pending_verdicts [$];
  int       mismatches = 0;
  int       hold_off   = 0;   // receiver hold-off request, in cycles
  bit       no_idle    = 1'b0; // drop the random gaps and stalls on both sides

  initial begin
    forever #5 clk = ~clk;
  end

  // Generous watchdog limit on the whole run.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [63:0] mag64(longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  // Floor square root of a 128-bit radicand, one bit per step.
  function automatic logic [63:0] floor_root(logic [127:0] n);
    logic [63:0]  res;
    logic [127:0] c;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      c = {64'b0, res | (64'd1 << b)};
      if (c * c <= n) res = c[63:0];
    end
    return res;
  endfunction

  // Distance in Q24.8 at time tq (Q16.16); each axis step is floored.
  function automatic logic [63:0] separation(pair_t pr, logic [31:0] tq);
    longint       pk, vk, prod;
    logic [63:0]  m;
    logic [127:0] acc;
    acc = '0;
    for (int k = 0; k < AXES; k++) begin
      pk   = longint'(pr.pos[k]);
      vk   = longint'(pr.vel[k]);
      prod = vk * longint'({32'b0, tq});
      m    = mag64(pk + (prod >>> 16));
      acc  = acc + {64'b0, m} * {64'b0, m};
    end
    return floor_root(acc);
  endfunction

  // Quotient saturated to 64 bits.
  function automatic logic [63:0] sat_div(logic [127:0] n, logic [63:0] d);
    logic [127:0] q;
    q = n / {64'b0, d};
    return (q[127:64] != 0) ? '1 : q[63:0];
  endfunction

  // Work out the verdict for one pair under the current register settings.
  function automatic verdict_t judge_pair(pair_t pr);
    verdict_t    vd;
    longint      pk, vk;
    logic [63:0] vv, pos_dot, neg_dot, mt, thr, ds, de, dm, rad, tstep;
    bit          interior, ev;
    vd = '{OC_NONE, '0, '0};
    if (!pr.overlap) return vd;
    vv = '0; pos_dot = '0; neg_dot = '0; mt = '0; tstep = '0;
    interior = 1'b0; ev = 1'b0;
    for (int k = 0; k < AXES; k++) begin
      pk = longint'(pr.pos[k]);
      vk = longint'(pr.vel[k]);
      vv = vv + mag64(vk) * mag64(vk);
      if ((pk < 0) != (vk < 0)) neg_dot = neg_dot + mag64(pk) * mag64(vk);
      else pos_dot = pos_dot + mag64(pk) * mag64(vk);
    end
    rad = {33'b0, pr.rad};
    // Interior minimum only when closing; zero velocity never has one.
    if (neg_dot > pos_dot && vv != 0) begin
      mt = sat_div({64'b0, neg_dot - pos_dot} << 16, vv);
      interior = mt < {32'b0, step_len};
    end
    thr = {48'b0, close_mult} * rad;
    ds = separation(pr, '0);
    de = separation(pr, step_len);
    if (!interior && (de << 8) > thr) return vd;
    dm = interior ? separation(pr, mt[31:0]) : ds;
    if (interior && dm <= de && dm < ds) begin
      tstep = mt;
      ev = 1'b1;
    end else if (de < dm && de < ds) begin
      dm = de;
      tstep = {32'b0, step_len};
      ev = 1'b1;
    end
    if (!ev) return vd;
    if (dm <= rad) begin
      vd.oc = OC_COLLISION;
      // Already overlapping at the start: contact at time zero.
      vd.t = (ds <= rad) ? '0 :
             TIME_W'(sat_div({64'b0, tstep} * {64'b0, ds - rad}, ds - dm));
      vd.d = pr.rad;
    end else if ((dm << 8) < thr) begin
      vd.oc = OC_CLOSE;
      vd.t = tstep[31:0];
      vd.d = (dm > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : dm[30:0];
    end
    return vd;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Compare every accepted result transaction with the oldest expectation.
  always @(posedge clk) begin
    verdict_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result", {62'b0, outcome}, '0);
      end else begin
        w = pending_verdicts.pop_front();
        if (outcome !== w.oc) report_mismatch("outcome", {62'b0, outcome}, {62'b0, w.oc});
        if (proximity_time !== w.t) report_mismatch("proximity_time", proximity_time, w.t);
        if (contact_distance !== w.d)
          report_mismatch("contact_distance", contact_distance, w.d);
      end
    end
  end

  // Receiver: draw a stall per result; honor a long hold-off when requested.
  initial begin
    int w;
    @(negedge rst);
    forever begin
      w = no_idle ? 0 : $urandom_range(0, 5);
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end else if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Offer one pair; hold it until the block takes the transaction.
  task automatic offer_pair(pair_t pr);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    cell_overlap <= pr.overlap;
    rel_pos_x <= pr.pos[0]; rel_pos_y <= pr.pos[1]; rel_pos_z <= pr.pos[2];
    rel_vel_x <= pr.vel[0]; rel_vel_y <= pr.vel[1]; rel_vel_z <= pr.vel[2];
    radius_sum   <= pr.rad;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_verdicts.insert(pending_verdicts.size(), judge_pair(pr));
  endtask

  // Write one register, then drop valid.
  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_CLOSE_FACTOR) close_mult = val[CF_W-1:0];
    else step_len = val;
    @(posedge clk);
  endtask

  // Wait for every result, then let the pipeline latency pass.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  function automatic pair_t build_pair(logic ov, longint px, longint py, longint pz,
                                       longint vx, longint vy, longint vz, longint r);
    pair_t pr;
    pr.overlap = ov;
    pr.pos[0] = coord_t'(px); pr.pos[1] = coord_t'(py); pr.pos[2] = coord_t'(pz);
    pr.vel[0] = coord_t'(vx); pr.vel[1] = coord_t'(vy); pr.vel[2] = coord_t'(vz);
    pr.rad = RAD_W'(r);
    return pr;
  endfunction

  // Mostly closing pairs at a random scale, with some raw noise and non-overlaps.
  function automatic pair_t random_pair();
    pair_t pr;
    int    kind, s, r;
    int signed raw;
    longint p;
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      pr.overlap = (kind != 0);
      for (int k = 0; k < AXES; k++) begin
        pr.pos[k] = $urandom();
        pr.vel[k] = $urandom();
      end
      pr.rad = RAD_W'($urandom());
      return pr;
    end
    pr.overlap = 1'b1;
    s = $urandom_range(3, 27);
    r = $urandom_range(2, 24);
    for (int k = 0; k < AXES; k++) begin
      raw = $urandom();
      p = longint'(raw >>> (31 - s));
      pr.pos[k] = coord_t'(p);
      raw = $urandom();
      pr.vel[k] = coord_t'(-(p * r) / 8 + longint'(raw >>> (34 - s)));
    end
    pr.rad = RAD_W'($urandom() & ((32'd1 << (s + 1)) - 1));
    return pr;
  endfunction

  // Extremes of every field plus each named special case.
  task automatic test_directed();
    offer_pair(build_pair(0, 1000, 0, 0, -1000, 0, 0, 100));          // no cell overlap
    offer_pair(build_pair(1, 5000, 0, 0, 0, 0, 0, 100));              // zero velocity
    offer_pair(build_pair(1, 5000, 0, 0, 0, 0, 0, 4000));             // static, close
    offer_pair(build_pair(1, 10000, 0, 0, -20000, 0, 0, 1000));       // head-on collision
    offer_pair(build_pair(1, 500, 0, 0, -100, 0, 0, 1000));           // already overlapping
    offer_pair(build_pair(1, 10000, 3000, 0, -20000, 0, 0, 2000));    // close pass
    offer_pair(build_pair(1, 10000, 0, 0, 5000, 0, 0, 9000));         // receding
    offer_pair(build_pair(1, 10000, 0, 0, -4000, 0, 0, 3500));        // minimum past the end
    offer_pair(build_pair(1, 10000, 0, 0, -4000, 0, 0, 7000));        // end-of-step contact
    offer_pair(build_pair(1, 10000, 0, 2000, -10000, 0, 0, 1999));    // tangent miss
    offer_pair(build_pair(1, 10000, 0, 2000, -10000, 0, 0, 2000));    // tangent touch
    offer_pair(build_pair(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, 31'h7FFF_FFFF));
    offer_pair(build_pair(1, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    offer_pair(build_pair(1, -32'sh8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 31'h7FFF_FFFF));
    offer_pair(build_pair(1, 0, 0, 0, 0, 0, 0, 0));                   // coincident, zero radius
    offer_pair(build_pair(1, 1, -1, 1, -1, 1, -1, 1));
    offer_pair(build_pair(1, -300000, 200000, 100000, 300000, -200000, -100000, 50));
    offer_pair(build_pair(1, 1000, 1000, 1000, -1, -1, -1, 31'h7FFF_FFFF));
  endtask

  task automatic test_random(int n);
    repeat (n) offer_pair(random_pair());
  endtask

  // Hold the receiver off long enough that the pipeline fills and stalls input.
  task automatic test_backpressure();
    hold_off = 400;
    no_idle = 1'b1;
    test_random(200);
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings first.
    test_directed();
    test_random(200);
    drain();

    // Smallest timestep, widest near-miss band.
    write_reg(REG_CLOSE_FACTOR, 32'd65535);
    write_reg(REG_TIMESTEP, 32'd1);
    test_directed();
    test_random(150);
    drain();

    // Longest timestep, narrowest band.
    write_reg(REG_CLOSE_FACTOR, 32'd256);
    write_reg(REG_TIMESTEP, 32'hFFFF_FFFF);
    test_random(150);
    drain();

    // Mid settings; run a stretch with no idling on either side.
    write_reg(REG_CLOSE_FACTOR, 32'($urandom_range(256, 4096)));
    write_reg(REG_TIMESTEP, 32'($urandom_range(1 << 14, 1 << 19)));
    no_idle = 1'b1;
    test_random(100);
    no_idle = 1'b0;
    test_random(100);
    drain();

    write_reg(REG_CLOSE_FACTOR, 32'd768);
    write_reg(REG_TIMESTEP, 32'd65536);
    test_backpressure();
    test_random(100);
    drain();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
